// ===== rtl/ffrd_pkg.sv =====
`timescale 1ns / 1ps

package ffrd_pkg;

    localparam int WORKERS      = 4;   // 1 to 4
    localparam int WORKER_SLOTS = 4;
    localparam int WORKER_W     = 2;
    localparam int UNIT_W       = 8;
    localparam int TAG_W        = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int QUEUE_DEPTH  = 2;   // power of two
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;

    typedef enum logic [0:0] {
        OP_REQUEST = 1'b0,
        OP_RELEASE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        OUT_GRANTED  = 2'd0,
        OUT_DEFERRED = 2'd1,
        OUT_REJECTED = 2'd2,
        OUT_RELEASED = 2'd3
    } t_outcome;

    // classified command held in the queue
    typedef struct packed {
        logic                is_release;
        logic                target_ok;
        logic [TAG_W-1:0]    tag;
        logic [UNIT_W-1:0]   amount;
        logic [WORKER_W-1:0] target;
    } t_cmd;

endpackage

// ===== rtl/ffrd_front.sv =====
`timescale 1ns / 1ps

module ffrd_front (
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ffrd_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_q_full,
    output logic                           o_push,
    output ffrd_pkg::t_cmd                 o_cmd
);
    import ffrd_pkg::*;

    logic [WORKER_W-1:0] target;

    assign target = i_s_tdata[TAG_W+UNIT_W +: WORKER_W];

    always_comb begin
        o_cmd.is_release = (t_opcode'(i_s_tuser) == OP_RELEASE);
        // a target beyond the populated workers is answered but changes nothing
        o_cmd.target_ok  = ({1'b0, target} < (WORKER_W+1)'(WORKERS));
        o_cmd.tag        = i_s_tdata[0 +: TAG_W];
        o_cmd.amount     = i_s_tdata[TAG_W +: UNIT_W];
        o_cmd.target     = target;
    end

    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

endmodule

// ===== rtl/ffrd_queue.sv =====
`timescale 1ns / 1ps

module ffrd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ffrd_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ffrd_pkg::t_cmd o_cmd
);
    import ffrd_pkg::*;

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/ffrd_back.sv =====
`timescale 1ns / 1ps

module ffrd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [ffrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffrd_pkg::UNIT_W-1:0]    i_cfg_data,
    input  logic                           i_q_valid,
    input  ffrd_pkg::t_cmd                 i_cmd,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ffrd_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [1:0]                     o_m_tuser
);
    import ffrd_pkg::*;

    logic [UNIT_W-1:0]   r_cap  [WORKER_SLOTS];
    logic [UNIT_W-1:0]   r_free [WORKER_SLOTS];

    logic                r_out_valid;
    t_outcome            r_outcome;
    logic [WORKER_W-1:0] r_worker;
    logic [TAG_W-1:0]    r_tag;
    logic [UNIT_W-1:0]   r_left;

    t_outcome            n_outcome;
    logic [WORKER_W-1:0] n_worker;
    logic [UNIT_W-1:0]   n_left;
    logic                upd_en;
    logic [UNIT_W:0]     rel_sum;
    logic [UNIT_W-1:0]   rel_val;
    logic                fits_some;
    logic                granted;
    logic [WORKER_W-1:0] pick;
    logic                cfg_hit;

    assign o_pop   = i_q_valid && (!r_out_valid || i_m_tready);
    assign cfg_hit = i_cfg_valid && (i_cfg_index < CFG_IDX_W'(WORKERS));

    // release: add and clamp at capacity
    always_comb begin
        rel_sum = {1'b0, r_free[i_cmd.target]} + {1'b0, i_cmd.amount};
        rel_val = (rel_sum > {1'b0, r_cap[i_cmd.target]}) ?
                  r_cap[i_cmd.target] : rel_sum[UNIT_W-1:0];
    end

    // request: first present worker with enough free units
    always_comb begin
        fits_some = 1'b0;
        granted   = 1'b0;
        pick      = '0;
        for (int k = 0; k < WORKERS; k++) begin
            if (r_cap[k] != '0) begin
                if (r_cap[k] >= i_cmd.amount) begin
                    fits_some = 1'b1;
                end
                if (!granted && r_free[k] >= i_cmd.amount) begin
                    granted = 1'b1;
                    pick    = WORKER_W'(k);
                end
            end
        end
    end

    always_comb begin
        upd_en = 1'b0;
        if (i_cmd.is_release) begin
            n_outcome = OUT_RELEASED;
            n_worker  = i_cmd.target;
            n_left    = i_cmd.target_ok ? rel_val : '0;
            upd_en    = i_cmd.target_ok;
        end else if (granted) begin
            n_outcome = OUT_GRANTED;
            n_worker  = pick;
            n_left    = r_free[pick] - i_cmd.amount;
            upd_en    = 1'b1;
        end else begin
            n_outcome = fits_some ? OUT_DEFERRED : OUT_REJECTED;
            n_worker  = '0;
            n_left    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WORKER_SLOTS; k++) begin
                r_cap[k]  <= '0;
                r_free[k] <= '0;
            end
        end else if (cfg_hit) begin
            r_cap[i_cfg_index[WORKER_W-1:0]]  <= i_cfg_data;
            r_free[i_cfg_index[WORKER_W-1:0]] <= i_cfg_data;
        end else if (o_pop && upd_en) begin
            r_free[n_worker] <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_outcome <= n_outcome;
            r_worker  <= n_worker;
            r_tag     <= i_cmd.tag;
            r_left    <= n_left;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_outcome;
    assign o_m_tdata  = {(M_TDATA_W-WORKER_W-TAG_W-UNIT_W)'(0), r_left, r_tag, r_worker};

endmodule

// ===== rtl/first_fit_resource_dispatcher_core.sv =====
`timescale 1ns / 1ps

// First-fit dispatcher for up to four prioritised workers (worker 0 ranks
// highest). A request is granted to the first present worker whose free units
// cover the amount and that worker is charged; otherwise it is deferred if some
// worker's capacity could hold it, or rejected. A release credits the named
// worker, clamped at its capacity. Writing a capacity register also refills
// that worker's free count; write capacities only while no transfer is in
// flight. An item passes from the input transfer through the queue write,
// then the compare and priority pick against the worker registers into the
// result register, which offers it as the result transfer. A two-entry
// queue sits between front and back, so one item per cycle is sustained
// when the output is not stalled.
module first_fit_resource_dispatcher_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffrd_pkg::UNIT_W-1:0]    i_cfg_data,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [ffrd_pkg::S_TDATA_W-1:0] i_s_tdata,  // request_tag, amount, target_worker
    input  logic                           i_s_tuser,  // opcode
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [ffrd_pkg::M_TDATA_W-1:0] o_m_tdata,  // granted_worker, tag_echo, units_left
    output logic [1:0]                     o_m_tuser   // outcome
);
    import ffrd_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd front_cmd;
    t_cmd back_cmd;

    assign o_cfg_ready = 1'b1;

    ffrd_front u_front (
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (front_cmd)
    );

    ffrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (back_cmd)
    );

    ffrd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule
